### rtl/core/pbc_pkg.sv
package pbc_pkg;

  localparam int CW       = 32;            // coordinate width
  localparam int HW       = 31;            // half size width
  localparam int GW       = 18;            // gain width
  localparam int MW       = 4;             // mode width
  localparam int NAX      = 3;
  localparam int QBITS    = 40;            // quotient bits below the clamp
  localparam int IN_W     = 200;
  localparam int OUT_W    = 232;

  // input beat bit positions
  localparam int IN_PRV   = 3 * CW;
  localparam int IN_WAS   = 6 * CW;
  localparam int IN_PASS  = 6 * CW + 1;

  // output beat bit positions
  localparam int OUT_PRV   = 3 * CW;
  localparam int OUT_HIT   = 6 * CW;
  localparam int OUT_KILL  = 6 * CW + 1;
  localparam int OUT_FIRST = 6 * CW + 2;
  localparam int OUT_RECOL = 6 * CW + 3;
  localparam int OUT_TOTAL = 6 * CW + 4;

  // mode register bits
  localparam int MODE_CAVITY  = 0;
  localparam int MODE_KILL    = 1;
  localparam int MODE_NORES   = 2;
  localparam int MODE_RECOLOR = 3;

  localparam logic [HW-1:0] HALF_RST = 31'd65536;
  localparam logic [GW-1:0] GAIN_RST = 18'd65536;
  localparam logic [MW-1:0] MODE_RST = 4'd0;

  typedef enum logic [2:0] {
    REG_HALF_X,
    REG_HALF_Y,
    REG_HALF_Z,
    REG_BOUNCE,
    REG_SLIDE,
    REG_MODE
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][31:0]       cur;
    logic [2:0][31:0]       prv;
    logic                   was_col;
    logic                   pass_start;
    logic [2:0]             live;
    logic [2:0]             side_pos;
    logic [2:0][32:0]       dir;
    logic [2:0][32:0]       nn;
    logic [2:0][31:0]       dd;
    logic [2:0][31:0]       plane;
    logic                   start_in;
    logic [2:0][63:0]       sqc;
    logic [2:0][61:0]       sqh;
    logic                   sphere_ok;
    logic [2:0][2:0][65:0]  xm;
    logic [2:0][2:0]        ltm;
    logic [1:0]             k;
    logic [32:0]            nk;
    logic [31:0]            dk;
    logic [31:0]            planek;
    logic [32:0]            dirk;
    logic                   sidek_pos;
    logic                   livek;
    logic [1:0][1:0]        ta;
    logic [1:0][32:0]       dj;
    logic                   fail;
    logic [1:0]             qneg;
    logic [1:0][63:0]       rem;
    logic [1:0]             sat;
    logic [1:0][QBITS-1:0]  q;
    logic [2:0][42:0]       cc;
    logic                   hit;
    logic [2:0][49:0]       gp;
    logic [2:0]             vneg;
  } item_t;

  // slab a ranks below slab b; a still axis sits just below zero (solid)
  // or beyond every finite parameter (cavity)
  function automatic logic rank_less(input logic cav, input logic la, input logic lb,
                                     input logic na_neg, input logic nb_neg,
                                     input logic lt_ab);
    logic r;
    if (la && lb) begin
      r = lt_ab;
    end else if (!la && !lb) begin
      r = 1'b0;
    end else if (cav) begin
      r = la;
    end else begin
      r = la ? na_neg : !nb_neg;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [44:0] x);
    logic [31:0] r;
    if (x > 45'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -45'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/particle_box_collide.sv
// Particle against box collider, streaming.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata, one particle per beat:
// current and previous position in the box frame (signed Q16.16), the
// particle's collided flag and a pass start flag. Each input beat yields
// exactly one output beat on m_tvalid/m_tready/m_tdata carrying the resolved
// positions, the hit/kill/first_hit/recolor flags and the running hit count.
// The cfg_* channel writes the box half sizes, gains and mode; it is always
// ready and is meant to be written while no particle is in flight.
//
// Throughput is one particle per cycle while the output beat is not held. An
// accepted input beat passes seven stages of setup (slab products, ranking,
// face choice, tangential products), a 40 stage restoring divider that forms
// the tangential hit coordinates one quotient bit per stage, two stages of
// bounds check and gain products, and the output register.
// The whole pipeline advances together: when the output beat is held by a
// low m_tready, every stage holds and s_tready drops in the same cycle, so
// nothing is lost or repeated. Reset (rst, synchronous) empties the pipeline,
// clears the hit counter and loads the default box (half sizes 1.0, gains
// 1.0, solid box, reflect mode).
module particle_box_collide (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // cur_x, cur_y, cur_z, prev_x, prev_y, prev_z, was_collided, pass_start, pad
  input  logic [pbc_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // out_cur_x, out_cur_y, out_cur_z, out_prev_x, out_prev_y, out_prev_z,
  // hit, kill, first_hit, recolor, hit_total, pad
  output logic [pbc_pkg::OUT_W-1:0] m_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data
);

  localparam int S_A    = 0;
  localparam int S_B    = 1;
  localparam int S_C    = 2;
  localparam int S_D    = 3;
  localparam int S_E    = 4;
  localparam int S_F    = 5;
  localparam int S_G    = 6;
  localparam int S_DIV0 = 7;
  localparam int S_H    = S_DIV0 + pbc_pkg::QBITS;
  localparam int S_I    = S_H + 1;
  localparam int NSTG   = S_I + 1;

  // configuration
  logic [2:0][pbc_pkg::HW-1:0] half;
  logic [pbc_pkg::GW-1:0]      bounce_gain;
  logic [pbc_pkg::GW-1:0]      slide_gain;
  logic [pbc_pkg::MW-1:0]      mode_bits;

  logic cav;
  assign cav       = mode_bits[pbc_pkg::MODE_CAVITY];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half        <= {3{pbc_pkg::HALF_RST}};
      bounce_gain <= pbc_pkg::GAIN_RST;
      slide_gain  <= pbc_pkg::GAIN_RST;
      mode_bits   <= pbc_pkg::MODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pbc_pkg::REG_HALF_X: half[0]     <= cfg_data[pbc_pkg::HW-1:0];
        pbc_pkg::REG_HALF_Y: half[1]     <= cfg_data[pbc_pkg::HW-1:0];
        pbc_pkg::REG_HALF_Z: half[2]     <= cfg_data[pbc_pkg::HW-1:0];
        pbc_pkg::REG_BOUNCE: bounce_gain <= cfg_data[pbc_pkg::GW-1:0];
        pbc_pkg::REG_SLIDE:  slide_gain  <= cfg_data[pbc_pkg::GW-1:0];
        pbc_pkg::REG_MODE:   mode_bits   <= cfg_data[pbc_pkg::MW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline
  logic            adv;
  logic [NSTG-1:0] vld;
  pbc_pkg::item_t  st [NSTG];
  pbc_pkg::item_t  nx_a, nx_b, nx_c, nx_d, nx_e, nx_f, nx_g, nx_h, nx_i;
  pbc_pkg::item_t  nx_div [pbc_pkg::QBITS];

  // advance everything unless the output beat is held
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage A: slab setup, start-inside test, squares for the sphere test
  always_comb begin
    logic signed [31:0] e, o, pl;
    logic signed [32:0] o33, h33, dir, n;
    logic [31:0]        ae;
    nx_a            = '0;
    nx_a.was_col    = s_tdata[pbc_pkg::IN_WAS];
    nx_a.pass_start = s_tdata[pbc_pkg::IN_PASS];
    nx_a.start_in   = 1'b1;
    for (int i = 0; i < pbc_pkg::NAX; i++) begin
      e   = s_tdata[32*i +: 32];
      o   = s_tdata[pbc_pkg::IN_PRV + 32*i +: 32];
      o33 = 33'(o);
      h33 = $signed({2'b00, half[i]});
      dir = 33'(e) - o33;
      if (dir > 0) begin
        pl = cav ? $signed({1'b0, half[i]}) : -$signed({1'b0, half[i]});
      end else if (dir < 0) begin
        pl = cav ? -$signed({1'b0, half[i]}) : $signed({1'b0, half[i]});
      end else begin
        pl = '0;
      end
      n = 33'(pl) - o33;
      if (dir < 0) begin
        n           = -n;
        nx_a.dd[i]  = 32'(-dir);
      end else begin
        nx_a.dd[i]  = dir[31:0];
      end
      nx_a.cur[i]      = e;
      nx_a.prv[i]      = o;
      nx_a.dir[i]      = dir;
      nx_a.nn[i]       = n;
      nx_a.plane[i]    = pl;
      nx_a.live[i]     = (dir != 0);
      nx_a.side_pos[i] = (dir < 0);
      if (!(o33 > -h33 && o33 < h33)) begin
        nx_a.start_in = 1'b0;
      end
      ae           = e[31] ? (~e + 32'd1) : e;
      nx_a.sqc[i]  = 64'(ae) * 64'(ae);
      nx_a.sqh[i]  = 62'(half[i]) * 62'(half[i]);
    end
  end

  // stage B: sphere test, cross products of slab fractions
  always_comb begin
    logic [63:0]        dsq, rad;
    logic signed [65:0] t;
    nx_b = st[S_A];
    dsq  = st[S_A].sqc[0] + st[S_A].sqc[1] + st[S_A].sqc[2];
    rad  = 64'(st[S_A].sqh[0]) + 64'(st[S_A].sqh[1]) + 64'(st[S_A].sqh[2]);
    nx_b.sphere_ok = dsq < rad;
    for (int a = 0; a < pbc_pkg::NAX; a++) begin
      for (int b = 0; b < pbc_pkg::NAX; b++) begin
        t = $signed(st[S_A].nn[a]) * $signed({1'b0, st[S_A].dd[b]});
        nx_b.xm[a][b] = t;
      end
    end
  end

  // stage C: exact fraction compares
  always_comb begin
    nx_c = st[S_B];
    for (int a = 0; a < pbc_pkg::NAX; a++) begin
      for (int b = 0; b < pbc_pkg::NAX; b++) begin
        nx_c.ltm[a][b] = $signed(st[S_B].xm[a][b]) < $signed(st[S_B].xm[b][a]);
      end
    end
  end

  // stage D: choose the struck axis, lower axis wins ties
  always_comb begin
    logic [1:0]     k1, k;
    pbc_pkg::item_t s;
    s    = st[S_C];
    nx_d = s;
    if (cav) begin
      k1 = pbc_pkg::rank_less(1'b1, s.live[1], s.live[0], s.nn[1][32], s.nn[0][32],
                              s.ltm[1][0]) ? 2'd1 : 2'd0;
      k  = pbc_pkg::rank_less(1'b1, s.live[2], s.live[k1], s.nn[2][32], s.nn[k1][32],
                              s.ltm[2][k1]) ? 2'd2 : k1;
    end else begin
      k1 = pbc_pkg::rank_less(1'b0, s.live[0], s.live[1], s.nn[0][32], s.nn[1][32],
                              s.ltm[0][1]) ? 2'd1 : 2'd0;
      k  = pbc_pkg::rank_less(1'b0, s.live[k1], s.live[2], s.nn[k1][32], s.nn[2][32],
                              s.ltm[k1][2]) ? 2'd2 : k1;
    end
    nx_d.k         = k;
    nx_d.nk        = s.nn[k];
    nx_d.dk        = s.dd[k];
    nx_d.planek    = s.plane[k];
    nx_d.dirk      = s.dir[k];
    nx_d.sidek_pos = s.side_pos[k];
    nx_d.livek     = s.live[k];
    case (k)
      2'd0:    nx_d.ta = {2'd2, 2'd1};
      2'd1:    nx_d.ta = {2'd2, 2'd0};
      default: nx_d.ta = {2'd1, 2'd0};
    endcase
    nx_d.dj[0] = s.dir[nx_d.ta[0]];
    nx_d.dj[1] = s.dir[nx_d.ta[1]];
  end

  // stage E: early rejects
  always_comb begin
    logic signed [32:0] fnum, rd, nk;
    logic               farpos;
    pbc_pkg::item_t     s;
    s      = st[S_D];
    nx_e   = s;
    nk     = $signed(s.nk);
    rd     = $signed(s.dirk);
    fnum   = 33'($signed(s.planek)) - 33'($signed(s.cur[s.k]));
    farpos = (fnum > 0 && rd > 0) || (fnum < 0 && rd < 0);
    nx_e.fail = !s.sphere_ok
             || (!cav && (!s.livek || nk < 0) && !s.start_in)
             || !s.livek
             || (farpos && nk > 0);
  end

  // stage F: numerators of the tangential coordinates
  always_comb begin
    logic [31:0] an, ad;
    pbc_pkg::item_t s;
    s    = st[S_E];
    nx_f = s;
    an   = s.nk[32] ? 32'(-$signed(s.nk)) : s.nk[31:0];
    for (int t = 0; t < 2; t++) begin
      ad           = s.dj[t][32] ? 32'(-$signed(s.dj[t])) : s.dj[t][31:0];
      nx_f.rem[t]  = 64'(an) * 64'(ad);
      nx_f.qneg[t] = s.nk[32] ^ s.dj[t][32];
    end
  end

  // stage G: clamp detect for quotients at or above the limit
  always_comb begin
    nx_g = st[S_F];
    for (int t = 0; t < 2; t++) begin
      nx_g.sat[t] = {8'b0, st[S_F].rem[t]} >= {st[S_F].dk, {pbc_pkg::QBITS{1'b0}}};
      nx_g.q[t]   = '0;
    end
  end

  // divider: one quotient bit per stage, most significant first
  for (genvar g = 0; g < pbc_pkg::QBITS; g++) begin : g_div
    localparam int B = pbc_pkg::QBITS - 1 - g;
    always_comb begin
      logic [71:0] sh;
      nx_div[g] = st[S_DIV0 + g - 1];
      sh        = {40'b0, st[S_DIV0 + g - 1].dk} << B;
      for (int t = 0; t < 2; t++) begin
        if ({8'b0, st[S_DIV0 + g - 1].rem[t]} >= sh) begin
          nx_div[g].rem[t]  = st[S_DIV0 + g - 1].rem[t] - sh[63:0];
          nx_div[g].q[t][B] = 1'b1;
        end
      end
    end
  end

  // stage H: hit point and bounds check on the tangential axes
  always_comb begin
    logic [40:0]        qm;
    logic signed [41:0] qs;
    logic signed [42:0] c, h43;
    logic               inb;
    pbc_pkg::item_t     s;
    s    = st[S_H - 1];
    nx_h = s;
    inb  = 1'b1;
    nx_h.cc = '0;
    for (int t = 0; t < 2; t++) begin
      qm  = s.sat[t] ? (41'd1 << pbc_pkg::QBITS) : {1'b0, s.q[t]};
      qs  = s.qneg[t] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      c   = 43'($signed(s.prv[s.ta[t]])) + 43'(qs);
      h43 = $signed({12'b0, half[s.ta[t]]});
      if (c < -h43 || c > h43) begin
        inb = 1'b0;
      end
      nx_h.cc[s.ta[t]] = c;
    end
    nx_h.cc[s.k] = 43'($signed(s.planek));
    nx_h.hit     = !s.fail && inb;
  end

  // stage I: gain products of the velocity components
  always_comb begin
    logic signed [32:0] v;
    logic [31:0]        av;
    logic [17:0]        g;
    pbc_pkg::item_t     s;
    s    = st[S_H];
    nx_i = s;
    for (int i = 0; i < pbc_pkg::NAX; i++) begin
      v  = 33'($signed(s.cur[i])) - 33'($signed(s.prv[i]));
      av = v[32] ? 32'(-v) : v[31:0];
      g  = (s.k == 2'(i)) ? bounce_gain : slide_gain;
      nx_i.gp[i]   = 50'(av) * 50'(g);
      nx_i.vneg[i] = v[32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[S_A] <= nx_a;
      st[S_B] <= nx_b;
      st[S_C] <= nx_c;
      st[S_D] <= nx_d;
      st[S_E] <= nx_e;
      st[S_F] <= nx_f;
      st[S_G] <= nx_g;
      for (int g = 0; g < pbc_pkg::QBITS; g++) begin
        st[S_DIV0 + g] <= nx_div[g];
      end
      st[S_H] <= nx_h;
      st[S_I] <= nx_i;
    end
  end

  // output: reflect, push off the face, saturate, count
  logic [31:0]               hit_counter, hit_counter_next;
  logic [31:0]               passes_since_hit, passes_since_hit_next;
  logic [pbc_pkg::OUT_W-1:0] beat_next;

  always_comb begin
    logic [34:0]        r;
    logic signed [35:0] gm;
    logic signed [44:0] cc, oc, op, side;
    logic               res, hit, kill;
    pbc_pkg::item_t     s;
    s    = st[S_I];
    hit  = s.hit;
    kill = hit && mode_bits[pbc_pkg::MODE_KILL];
    res  = hit && !kill && !mode_bits[pbc_pkg::MODE_NORES];
    side = s.sidek_pos ? 45'sd1 : -45'sd1;
    beat_next = '0;
    for (int i = 0; i < pbc_pkg::NAX; i++) begin
      r  = 35'((51'(s.gp[i]) + 51'd32768) >> 16);
      gm = s.vneg[i] ? -$signed({1'b0, r}) : $signed({1'b0, r});
      cc = 45'($signed(s.cc[i]));
      if (!res) begin
        oc = 45'($signed(s.cur[i]));
        op = 45'($signed(s.prv[i]));
      end else if (s.k == 2'(i)) begin
        oc = cc - 45'(gm) + side;
        op = cc + side;
      end else begin
        oc = cc;
        op = cc - 45'(gm);
      end
      beat_next[32*i +: 32]                   = pbc_pkg::sat32(oc);
      beat_next[pbc_pkg::OUT_PRV + 32*i +: 32] = pbc_pkg::sat32(op);
    end
    hit_counter_next = (hit && hit_counter != 32'hffff_ffff) ? hit_counter + 32'd1
                                                              : hit_counter;
    passes_since_hit_next = passes_since_hit;
    if (s.pass_start && passes_since_hit != 32'hffff_ffff) begin
      passes_since_hit_next = passes_since_hit + 32'd1;
    end
    if (hit) begin
      passes_since_hit_next = '0;
    end
    beat_next[pbc_pkg::OUT_HIT]   = hit;
    beat_next[pbc_pkg::OUT_KILL]  = kill;
    beat_next[pbc_pkg::OUT_FIRST] = hit && !s.was_col;
    beat_next[pbc_pkg::OUT_RECOL] = hit && !kill && mode_bits[pbc_pkg::MODE_RECOLOR];
    beat_next[pbc_pkg::OUT_TOTAL +: 32] = hit_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid         <= 1'b0;
      hit_counter      <= '0;
      passes_since_hit <= '0;
    end else if (adv) begin
      m_tvalid <= vld[S_I];
      if (vld[S_I]) begin
        hit_counter      <= hit_counter_next;
        passes_since_hit <= passes_since_hit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[S_I]) begin
      m_tdata <= beat_next;
    end
  end

endmodule

### rtl/core/pbc_chk.sv
module pbc_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [pbc_pkg::OUT_W-1:0] m_tdata
);

  // held output beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // a stalled output freezes the whole pipe, input included
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // flags only come with a hit, kill and recolor exclude each other
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[pbc_pkg::OUT_KILL] || m_tdata[pbc_pkg::OUT_HIT])
              && (!m_tdata[pbc_pkg::OUT_FIRST] || m_tdata[pbc_pkg::OUT_HIT])
              && (!m_tdata[pbc_pkg::OUT_RECOL] ||
                  (m_tdata[pbc_pkg::OUT_HIT] && !m_tdata[pbc_pkg::OUT_KILL])))
    else $error("result flags inconsistent");

  // a hit beat always shows a nonzero count
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[pbc_pkg::OUT_HIT] |-> m_tdata[pbc_pkg::OUT_TOTAL +: 32] != 32'd0)
    else $error("hit with zero hit count");

endmodule

bind particle_box_collide pbc_chk u_pbc_chk (.*);
